FILE: design/length_prefixed_packet_ring_core_macros.svh
// Assertion macros used by the packet ring checker
`ifndef LENGTH_PREFIXED_PACKET_RING_CORE_MACROS_SVH
`define LENGTH_PREFIXED_PACKET_RING_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define LPR_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LPR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/lpr_pkg.sv
// Shared types, constants and helpers of the packet ring
package lpr_pkg;

	localparam int BUF_DEPTH = 1024;
	localparam int MAX_PKT   = 64;
	localparam int PTR_W     = $clog2(BUF_DEPTH);
	localparam int CNT_W     = 11;
	localparam int LEN_W     = 7;
	localparam int CAP_W     = 16;
	localparam int MIN_SIZE  = 4;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [LEN_W-1:0] len_t;

	localparam cnt_t HDR_BYTES = CNT_W'(2);

	localparam logic [1:0] REQ_PUSH_START = 2'd0;
	localparam logic [1:0] REQ_PUSH_BYTE  = 2'd1;
	localparam logic [1:0] REQ_POP        = 2'd2;
	localparam logic [1:0] REQ_CLEAR      = 2'd3;

	localparam logic REG_BUFFER_SIZE = 1'b0;
	localparam logic REG_MAX_LEN     = 1'b1;

	typedef enum logic [2:0] {
		ST_PUSH_OK    = 3'd0,
		ST_PUSH_REF   = 3'd1,
		ST_REF_RESET  = 3'd2,
		ST_DATA       = 3'd3,
		ST_POP_REF    = 3'd4,
		ST_CLEARED    = 3'd5,
		ST_BUSY       = 3'd6,
		ST_EMPTY_PKT  = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HDR_HI,
		S_POP_LO,
		S_POP_HI,
		S_POP_EMPTY,
		S_POP_DATA
	} ctl_state_t;

	typedef struct packed {
		logic    wr_hdr_lo;
		logic    wr_hdr_hi;
		logic    wr_byte;
		logic    flush;
		logic    rd_hdr;
		logic    rd_data;
		logic    latch_lo;
		logic    pop_commit;
		logic    emit;
		status_t emit_st;
	} dp_cmd_t;

	typedef struct packed {
		logic push_open;
		logic push_fits;
		logic ring_skew;
		logic pop_ok;
		logic pop_cnt_zero;
		logic iss_left;
		logic pend;
		logic emit_last;
		logic out_free;
	} dp_sts_t;

	function automatic cnt_t eff_size(input cnt_t reg_val);
		cnt_t s;
		s = reg_val;
		if (s < CNT_W'(MIN_SIZE)) s = CNT_W'(MIN_SIZE);
		if (s > CNT_W'(BUF_DEPTH)) s = CNT_W'(BUF_DEPTH);
		return s;
	endfunction

	function automatic len_t eff_limit(input len_t reg_val);
		return (reg_val > LEN_W'(MAX_PKT)) ? LEN_W'(MAX_PKT) : reg_val;
	endfunction

	function automatic ptr_t ptr_adv(input ptr_t p, input cnt_t size);
		logic [PTR_W:0] n;
		n = {1'b0, p} + (PTR_W+1)'(1);
		return (CNT_W'(n) >= size) ? '0 : n[PTR_W-1:0];
	endfunction

endpackage

FILE: design/lpr_in_if.sv
// Request channel: valid/ready plus request payload
interface lpr_in_if import lpr_pkg::*;;
	logic             valid;
	logic             ready;
	logic [1:0]       req_type;
	logic [LEN_W-1:0] pkt_len;
	logic [7:0]       data_byte;
	logic [CAP_W-1:0] reader_capacity;

	modport source (output valid, req_type, pkt_len, data_byte, reader_capacity, input ready);
	modport sink (input valid, req_type, pkt_len, data_byte, reader_capacity, output ready);
endinterface

FILE: design/lpr_out_if.sv
// Result channel: valid/ready plus result payload
interface lpr_out_if import lpr_pkg::*;;
	logic             valid;
	logic             ready;
	logic [2:0]       status;
	logic [7:0]       out_byte;
	logic [LEN_W-1:0] out_len;
	logic             last;
	logic [CNT_W-1:0] fill_level;
	logic [CNT_W-1:0] peak_fill;

	modport source (output valid, status, out_byte, out_len, last, fill_level, peak_fill,
		input ready);
	modport sink (input valid, status, out_byte, out_len, last, fill_level, peak_fill,
		output ready);
endinterface

FILE: design/lpr_dp.sv
// Ring datapath: byte memory, pointers, fill counters, pop counters, result register
module lpr_dp import lpr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cnt_t             size_eff,
	input  len_t             limit_eff,
	input  logic             cfg_flush,
	input  logic [LEN_W-1:0] pkt_len,
	input  logic [7:0]       data_byte,
	input  logic [CAP_W-1:0] reader_capacity,
	input  dp_cmd_t          cmd,
	output dp_sts_t          sts,
	lpr_out_if.source        rsp
);

	logic [7:0] mem [BUF_DEPTH];
	logic [7:0] rdata_q;

	ptr_t wp_q, rp_q, wp_d, rp_d;
	cnt_t held_q, peak_q, held_d, peak_d;
	len_t rem_q, plen_q, rem_d, plen_d;
	logic open_q, open_d;

	logic [7:0] lo_q;
	len_t       pop_len_q, iss_q, emt_q;
	logic       pend_q;

	logic             out_valid_q;
	status_t          out_st_q;
	logic [7:0]       out_byte_q;
	len_t             out_len_q;
	logic             out_last_q;
	cnt_t             out_fill_q, out_peak_q;

	logic             wr_en;
	logic [7:0]       wdata;
	logic             commit_en;
	len_t             commit_len, rem_dec;
	logic [CNT_W:0]   held_sum, skew_sum;
	logic [15:0]      len16;
	len_t             c1, cnt;
	cnt_t             held_m2;
	logic             emit_data;

	assign wr_en = cmd.wr_hdr_lo | cmd.wr_hdr_hi | cmd.wr_byte;
	assign wdata = cmd.wr_hdr_lo ? {1'b0, pkt_len} : (cmd.wr_hdr_hi ? 8'h00 : data_byte);

	always_ff @(posedge clk) begin
		if (wr_en) mem[wp_q] <= wdata;
		if (cmd.rd_hdr | cmd.rd_data) rdata_q <= mem[rp_q];
	end

	// header length, bounded by MAX_PKT and by the bytes held after the header
	assign len16   = {rdata_q, lo_q};
	assign c1      = (len16 > 16'(MAX_PKT)) ? LEN_W'(MAX_PKT) : len16[LEN_W-1:0];
	assign held_m2 = held_q - HDR_BYTES;
	assign cnt     = (CNT_W'(c1) > held_m2) ? held_m2[LEN_W-1:0] : c1;

	assign rem_dec    = (rem_q != '0) ? rem_q - LEN_W'(1) : '0;
	assign commit_len = cmd.wr_hdr_lo ? pkt_len : plen_q;
	assign commit_en  = (cmd.wr_hdr_lo && pkt_len == '0) || (cmd.wr_byte && rem_dec == '0);
	assign held_sum   = {1'b0, held_q} + (CNT_W+1)'(commit_len) + {1'b0, HDR_BYTES};
	assign emit_data  = cmd.emit && cmd.emit_st == ST_DATA;

	always_comb begin
		skew_sum = {1'b0, held_q} + (CNT_W+1)'(rp_q);
		if (skew_sum >= {1'b0, size_eff}) skew_sum = skew_sum - {1'b0, size_eff};
	end

	always_comb begin
		wp_d   = wp_q;
		rp_d   = rp_q;
		held_d = held_q;
		peak_d = peak_q;
		rem_d  = rem_q;
		plen_d = plen_q;
		open_d = open_q;
		if (wr_en) wp_d = ptr_adv(wp_q, size_eff);
		if (cmd.rd_hdr | cmd.rd_data) rp_d = ptr_adv(rp_q, size_eff);
		if (cmd.flush) begin
			rp_d   = wp_q;
			held_d = '0;
		end
		if (cmd.wr_hdr_lo) begin
			plen_d = pkt_len;
			rem_d  = pkt_len;
			open_d = 1'b1;
		end
		if (cmd.wr_byte) rem_d = rem_dec;
		if (commit_en) begin
			held_d = held_sum[CNT_W-1:0];
			if (held_sum[CNT_W-1:0] > peak_q) peak_d = held_sum[CNT_W-1:0];
			open_d = 1'b0;
			rem_d  = '0;
			plen_d = '0;
		end
		if (cmd.pop_commit) held_d = held_m2 - CNT_W'(cnt);
		if (cfg_flush) begin
			wp_d   = '0;
			rp_d   = '0;
			held_d = '0;
			rem_d  = '0;
			plen_d = '0;
			open_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			held_q <= '0;
			peak_q <= '0;
			rem_q  <= '0;
			plen_q <= '0;
			open_q <= 1'b0;
		end else begin
			wp_q   <= wp_d;
			rp_q   <= rp_d;
			held_q <= held_d;
			peak_q <= peak_d;
			rem_q  <= rem_d;
			plen_q <= plen_d;
			open_q <= open_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_lo) lo_q <= rdata_q;
		if (cmd.pop_commit) pop_len_q <= len16[LEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q  <= '0;
			emt_q  <= '0;
			pend_q <= 1'b0;
		end else begin
			if (cmd.pop_commit) begin
				iss_q <= cnt;
				emt_q <= cnt;
			end else begin
				if (cmd.rd_data) iss_q <= iss_q - LEN_W'(1);
				if (emit_data) emt_q <= emt_q - LEN_W'(1);
			end
			if (cmd.rd_data) pend_q <= 1'b1;
			else if (emit_data) pend_q <= 1'b0;
		end
	end

	// result register; fill and peak are the values after this step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.emit) out_valid_q <= 1'b1;
		else if (rsp.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_st_q   <= cmd.emit_st;
			out_byte_q <= emit_data ? rdata_q : 8'h00;
			out_len_q  <= (emit_data || cmd.emit_st == ST_EMPTY_PKT) ? pop_len_q : '0;
			out_last_q <= emit_data ? (emt_q == LEN_W'(1)) : 1'b1;
			out_fill_q <= held_d;
			out_peak_q <= peak_d;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_st_q;
	assign rsp.out_byte   = out_byte_q;
	assign rsp.out_len    = out_len_q;
	assign rsp.last       = out_last_q;
	assign rsp.fill_level = out_fill_q;
	assign rsp.peak_fill  = out_peak_q;

	always_comb begin
		sts.push_open    = open_q;
		sts.push_fits    = (pkt_len <= limit_eff) &&
			(({1'b0, held_q} + (CNT_W+1)'(pkt_len) + {1'b0, HDR_BYTES}) <= {1'b0, size_eff});
		sts.ring_skew    = (skew_sum != (CNT_W+1)'(wp_q));
		sts.pop_ok       = (held_q > HDR_BYTES) && (reader_capacity >= CAP_W'(limit_eff));
		sts.pop_cnt_zero = (cnt == '0);
		sts.iss_left     = (iss_q != '0);
		sts.pend         = pend_q;
		sts.emit_last    = (emt_q == LEN_W'(1));
		sts.out_free     = !out_valid_q || rsp.ready;
	end

endmodule

FILE: design/lpr_ctrl.sv
// Ring controller: request decode, header write, pop sequencing
module lpr_ctrl import lpr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_type,
	input  dp_sts_t    sts,
	output dp_cmd_t    cmd,
	output logic       in_ready
);

	ctl_state_t state_q, state_d;
	logic       emit_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.emit_st = ST_PUSH_OK;
		in_ready    = 1'b0;
		emit_byte   = sts.pend && sts.out_free;
		case (state_q)
			S_IDLE: begin
				in_ready = sts.out_free;
				if (req_valid && sts.out_free) begin
					cmd.emit = 1'b1;
					case (req_type)
						REQ_PUSH_START: begin
							if (sts.push_open) begin
								cmd.emit_st = ST_BUSY;
							end else if (sts.push_fits) begin
								cmd.wr_hdr_lo = 1'b1;
								cmd.emit_st   = ST_PUSH_OK;
								state_d       = S_HDR_HI;
							end else if (sts.ring_skew) begin
								cmd.flush   = 1'b1;
								cmd.emit_st = ST_REF_RESET;
							end else begin
								cmd.emit_st = ST_PUSH_REF;
							end
						end
						REQ_PUSH_BYTE: begin
							if (sts.push_open) begin
								cmd.wr_byte = 1'b1;
								cmd.emit_st = ST_PUSH_OK;
							end else begin
								cmd.emit_st = ST_PUSH_REF;
							end
						end
						REQ_POP: begin
							if (sts.push_open) begin
								cmd.emit_st = ST_BUSY;
							end else if (sts.pop_ok) begin
								cmd.emit   = 1'b0;
								cmd.rd_hdr = 1'b1;
								state_d    = S_POP_LO;
							end else begin
								cmd.emit_st = ST_POP_REF;
							end
						end
						REQ_CLEAR: begin
							if (sts.push_open) begin
								cmd.emit_st = ST_BUSY;
							end else begin
								cmd.flush   = 1'b1;
								cmd.emit_st = ST_CLEARED;
							end
						end
						default: begin
							cmd.emit_st = ST_PUSH_REF;
						end
					endcase
				end
			end
			S_HDR_HI: begin
				cmd.wr_hdr_hi = 1'b1;
				state_d       = S_IDLE;
			end
			S_POP_LO: begin
				cmd.latch_lo = 1'b1;
				cmd.rd_hdr   = 1'b1;
				state_d      = S_POP_HI;
			end
			S_POP_HI: begin
				cmd.pop_commit = 1'b1;
				state_d        = sts.pop_cnt_zero ? S_POP_EMPTY : S_POP_DATA;
			end
			S_POP_EMPTY: begin
				if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.emit_st = ST_EMPTY_PKT;
					state_d     = S_IDLE;
				end
			end
			S_POP_DATA: begin
				// next read goes out when bytes remain to be read and the read data slot is empty or drains now
				cmd.rd_data = sts.iss_left && (!sts.pend || emit_byte);
				cmd.emit    = emit_byte;
				cmd.emit_st = ST_DATA;
				if (emit_byte && sts.emit_last) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: design/length_prefixed_packet_ring_core.sv
// Packet ring top: result is registered; push start stays busy through two header writes.
// Push byte, clear and refusals: one transfer per cycle while results drain.
// Pop: 2 header reads, a length check and a first-byte fetch, then one data byte per
// cycle while results drain.
// Reset clears pointers, fill and peak counters and sets size 1024, limit 64;
// ring memory contents are not cleared.
module length_prefixed_packet_ring_core import lpr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	lpr_in_if.sink      req,
	lpr_out_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cnt_t    size_q;
	len_t    maxlen_q;
	logic    reg_wr;
	logic    cfg_flush;
	dp_cmd_t cmd;
	dp_sts_t sts;

	assign pready    = 1'b1;
	assign reg_wr    = psel && penable && pwrite && pready;
	assign cfg_flush = reg_wr && (paddr[2] == REG_BUFFER_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= CNT_W'(BUF_DEPTH);
			maxlen_q <= LEN_W'(MAX_PKT);
		end else if (reg_wr) begin
			if (paddr[2] == REG_BUFFER_SIZE) size_q <= pwdata[CNT_W-1:0];
			else maxlen_q <= pwdata[LEN_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_MAX_LEN) ? 32'(maxlen_q) : 32'(size_q);

	lpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.sts       (sts),
		.cmd       (cmd),
		.in_ready  (req.ready)
	);

	lpr_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.size_eff        (eff_size(size_q)),
		.limit_eff       (eff_limit(maxlen_q)),
		.cfg_flush       (cfg_flush),
		.pkt_len         (req.pkt_len),
		.data_byte       (req.data_byte),
		.reader_capacity (req.reader_capacity),
		.cmd             (cmd),
		.sts             (sts),
		.rsp             (rsp)
	);

endmodule

FILE: design/lpr_checker.sv
// Port-level checks of the packet ring and their bind to the top level
`include "length_prefixed_packet_ring_core_macros.svh"

module lpr_checker import lpr_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic [2:0]       out_status,
	input logic             out_last,
	input logic [CNT_W-1:0] out_fill,
	input logic [CNT_W-1:0] out_peak
);

	`LPR_ASSERT_IMPL(a_fill_below_peak, out_valid, out_fill <= out_peak, "fill above peak")
	`LPR_ASSERT_NEXT(a_peak_monotonic, out_valid && out_ready, !out_valid || out_peak >= $past(out_peak), "peak fell")
	`LPR_ASSERT_IMPL(a_single_is_last, out_valid && out_status != ST_DATA, out_last, "non-data result without last")
	`LPR_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_fill), "stalled result changed")

endmodule

bind length_prefixed_packet_ring_core lpr_checker u_lpr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (rsp.valid),
	.out_ready  (rsp.ready),
	.out_status (rsp.status),
	.out_last   (rsp.last),
	.out_fill   (rsp.fill_level),
	.out_peak   (rsp.peak_fill)
);

FILE: verif/testbench.sv
// Self-checking testbench for the packet ring core: queued requests, own ring predictor
module testbench;
	import lpr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]       req_type;
		len_t             pkt_len;
		logic [7:0]       data_byte;
		logic [CAP_W-1:0] reader_capacity;
	} ring_req_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] out_byte;
		len_t       out_len;
		logic       last;
		cnt_t       fill_level;
		cnt_t       peak_fill;
	} ring_rsp_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	lpr_in_if  req_ch ();
	lpr_out_if rsp_ch ();

	length_prefixed_packet_ring_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predicted ring contents and bookkeeping
	logic [7:0]  ring_mem [0:BUF_DEPTH-1];
	int unsigned wr_pos, rd_pos, held, peak, bytes_left, open_len;
	bit          push_active;
	int unsigned cfg_size = 1024;
	int unsigned cfg_limit = 64;

	ring_req_t pending_reqs [$];
	ring_rsp_t expected_rsps [$];
	ring_req_t cur_req;
	ring_rsp_t got_rsp, want_rsp;
	int        mismatches = 0;
	int        send_gap = 0;
	int        hold_cnt = 0;
	bit        idle_on = 1'b1;

	always #1 clk = ~clk;

	function automatic int unsigned ring_size();
		if (cfg_size < MIN_SIZE) return MIN_SIZE;
		if (cfg_size > BUF_DEPTH) return BUF_DEPTH;
		return cfg_size;
	endfunction

	function automatic int unsigned pkt_limit();
		return (cfg_limit > MAX_PKT) ? MAX_PKT : cfg_limit;
	endfunction

	function automatic void ring_put(input logic [7:0] b);
		ring_mem[wr_pos] = b;
		wr_pos = (wr_pos + 1 >= ring_size()) ? 0 : wr_pos + 1;
	endfunction

	function automatic logic [7:0] ring_take();
		logic [7:0] b;
		b = ring_mem[rd_pos];
		rd_pos = (rd_pos + 1 >= ring_size()) ? 0 : rd_pos + 1;
		return b;
	endfunction

	function automatic void commit_packet();
		held += open_len + HDR_BYTES;
		if (held > peak) peak = held;
		push_active = 1'b0;
		bytes_left = 0;
		open_len = 0;
	endfunction

	function automatic void empty_ring();
		wr_pos = 0;
		rd_pos = 0;
		held = 0;
		push_active = 1'b0;
		bytes_left = 0;
		open_len = 0;
	endfunction

	function automatic ring_rsp_t mk_rsp(input status_t st, input logic [7:0] b, input len_t len);
		ring_rsp_t r;
		r = '0;
		r.status = st;
		r.out_byte = b;
		r.out_len = len;
		return r;
	endfunction

	function automatic string fmt_rsp(input ring_rsp_t r);
		return $sformatf("st=%0d byte=%02h len=%0d last=%0b fill=%0d peak=%0d",
			r.status, r.out_byte, r.out_len, r.last, r.fill_level, r.peak_fill);
	endfunction

	// expected results of one accepted request, in order
	function automatic void predict_request(input ring_req_t r);
		ring_rsp_t   res [$];
		ring_rsp_t   e;
		int unsigned size, hdr_len, cnt;
		logic [7:0]  lo, hi;
		size = ring_size();
		case (r.req_type)
			REQ_PUSH_START: begin
				if (push_active) begin
					res.push_back(mk_rsp(ST_BUSY, 0, 0));
				end else if (r.pkt_len <= pkt_limit() && held + r.pkt_len + HDR_BYTES <= size) begin
					ring_put(8'(r.pkt_len));
					ring_put(8'h00);
					open_len = r.pkt_len;
					bytes_left = r.pkt_len;
					push_active = 1'b1;
					if (r.pkt_len == 0) commit_packet();
					res.push_back(mk_rsp(ST_PUSH_OK, 0, 0));
				end else if ((held + rd_pos) % size != wr_pos) begin
					held = 0;
					rd_pos = wr_pos;
					res.push_back(mk_rsp(ST_REF_RESET, 0, 0));
				end else begin
					res.push_back(mk_rsp(ST_PUSH_REF, 0, 0));
				end
			end
			REQ_PUSH_BYTE: begin
				if (!push_active) begin
					res.push_back(mk_rsp(ST_PUSH_REF, 0, 0));
				end else begin
					ring_put(r.data_byte);
					if (bytes_left > 0) bytes_left--;
					if (bytes_left == 0) commit_packet();
					res.push_back(mk_rsp(ST_PUSH_OK, 0, 0));
				end
			end
			REQ_POP: begin
				if (push_active) begin
					res.push_back(mk_rsp(ST_BUSY, 0, 0));
				end else if (held > HDR_BYTES && r.reader_capacity >= pkt_limit()) begin
					lo = ring_take();
					hi = ring_take();
					hdr_len = {hi, lo};
					cnt = hdr_len;
					held -= HDR_BYTES;
					if (cnt > MAX_PKT) cnt = MAX_PKT;
					if (cnt > held) cnt = held;
					if (cnt == 0) begin
						res.push_back(mk_rsp(ST_EMPTY_PKT, 0, len_t'(hdr_len)));
					end else begin
						for (int k = 0; k < cnt; k++)
							res.push_back(mk_rsp(ST_DATA, ring_take(), len_t'(hdr_len)));
						held -= cnt;
					end
				end else begin
					res.push_back(mk_rsp(ST_POP_REF, 0, 0));
				end
			end
			default: begin
				if (push_active) begin
					res.push_back(mk_rsp(ST_BUSY, 0, 0));
				end else begin
					rd_pos = wr_pos;
					held = 0;
					res.push_back(mk_rsp(ST_CLEARED, 0, 0));
				end
			end
		endcase
		for (int k = 0; k < res.size(); k++) begin
			e = res[k];
			e.last = (k == res.size() - 1);
			e.fill_level = cnt_t'(held);
			e.peak_fill = cnt_t'(peak);
			expected_rsps.push_back(e);
		end
	endfunction

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				predict_request(cur_req);
			if (!req_ch.valid || req_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req_ch.valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					cur_req = pending_reqs.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.req_type <= cur_req.req_type;
					req_ch.pkt_len <= cur_req.pkt_len;
					req_ch.data_byte <= cur_req.data_byte;
					req_ch.reader_capacity <= cur_req.reader_capacity;
					if (idle_on && $urandom_range(0, 99) < 20)
						send_gap = $urandom_range(1, 4);
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random back-pressure
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_cnt = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got_rsp = '{status_t'(rsp_ch.status), rsp_ch.out_byte, rsp_ch.out_len,
					rsp_ch.last, rsp_ch.fill_level, rsp_ch.peak_fill};
				if (expected_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t unexpected transfer: %s", $realtime, fmt_rsp(got_rsp));
				end else begin
					want_rsp = expected_rsps.pop_front();
					if (got_rsp !== want_rsp) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t mismatch: expected %s", $realtime, fmt_rsp(want_rsp));
							$display("%0t           actual   %s", $realtime, fmt_rsp(got_rsp));
						end
					end
				end
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				rsp_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 99) < 20) begin
				hold_cnt = $urandom_range(0, 3);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// unused fields get random values so every payload bit moves
	task automatic add_req(input logic [1:0] kind, input int unsigned val);
		ring_req_t r;
		r.req_type = kind;
		r.pkt_len = len_t'($urandom_range(0, 127));
		r.data_byte = 8'($urandom);
		r.reader_capacity = 16'($urandom);
		case (kind)
			REQ_PUSH_START: r.pkt_len = len_t'(val);
			REQ_PUSH_BYTE:  r.data_byte = 8'(val);
			REQ_POP:        r.reader_capacity = 16'(val);
			default: ;
		endcase
		pending_reqs.push_back(r);
	endtask

	task automatic wait_drain();
		do @(negedge clk);
		while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0);
	endtask

	// APB write: setup, then access; predictor follows at the access edge
	task automatic write_reg(input logic idx, input int unsigned val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_BUFFER_SIZE) begin
			cfg_size = val & 'h7FF;
			empty_ring();
		end else begin
			cfg_limit = val & 'h7F;
		end
	endtask

	// mostly complete packets with random content, plus pops, clears and noise
	task automatic queue_mix(input int n_items);
		int          added, pick, len, cut, lim, small_max, r;
		int unsigned cap;
		added = 0;
		lim = pkt_limit();
		small_max = (lim < 6) ? lim : 6;
		while (added < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				r = $urandom_range(0, 99);
				if (r < 75) len = $urandom_range(0, small_max);
				else if (r < 90) len = lim;
				else len = $urandom_range(0, 127);
				// keep long packets within the phase budget
				if (len <= lim && len + 1 > n_items - added) len = $urandom_range(0, small_max);
				add_req(REQ_PUSH_START, len);
				added++;
				if (len <= lim) begin
					for (int k = 0; k < len; k++) add_req(REQ_PUSH_BYTE, $urandom_range(0, 255));
					added += len;
				end
			end else if (pick < 60) begin
				// packet interrupted by a request that must come back busy
				len = $urandom_range(1, (small_max > 1) ? small_max : 1);
				cut = $urandom_range(0, len - 1);
				add_req(REQ_PUSH_START, len);
				for (int k = 0; k < cut; k++) add_req(REQ_PUSH_BYTE, $urandom_range(0, 255));
				r = $urandom_range(0, 2);
				if (r == 0) add_req(REQ_POP, 16'hFFFF);
				else if (r == 1) add_req(REQ_CLEAR, 0);
				else add_req(REQ_PUSH_START, $urandom_range(0, 127));
				for (int k = cut; k < len; k++) add_req(REQ_PUSH_BYTE, $urandom_range(0, 255));
				added += len + 2;
			end else if (pick < 82) begin
				r = $urandom_range(0, 9);
				if (r < 6) cap = $urandom_range(lim, 65535);
				else if (r == 6) cap = lim;
				else if (r == 7) cap = 65535;
				else cap = $urandom_range(0, 65535);
				add_req(REQ_POP, cap);
				added++;
			end else if (pick < 90) begin
				add_req(REQ_CLEAR, 0);
				added++;
			end else begin
				add_req(REQ_PUSH_BYTE, $urandom_range(0, 255));
				added++;
			end
		end
	endtask

	task automatic run_phase(input int unsigned size_val, input int unsigned lim_val,
		input int n_items, input bit with_idle);
		wait_drain();
		repeat (4) @(posedge clk);
		write_reg(REG_BUFFER_SIZE, size_val);
		write_reg(REG_MAX_LEN, lim_val);
		idle_on = with_idle;
		queue_mix(n_items);
		wait_drain();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_PUSH_START;
		req_ch.pkt_len = '0;
		req_ch.data_byte = '0;
		req_ch.reader_capacity = '0;
		rsp_ch.ready = 1'b0;
		foreach (ring_mem[i]) ring_mem[i] = '0;
		empty_ring();
		peak = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty ring, stray byte, zero-length packets, busy, limits
		add_req(REQ_POP, 16'hFFFF);
		add_req(REQ_PUSH_BYTE, 8'hFF);
		add_req(REQ_CLEAR, 0);
		add_req(REQ_PUSH_START, 0);
		add_req(REQ_POP, 16'hFFFF);
		add_req(REQ_PUSH_START, 0);
		add_req(REQ_POP, 64);
		add_req(REQ_PUSH_START, 3);
		add_req(REQ_POP, 16'hFFFF);
		add_req(REQ_CLEAR, 0);
		add_req(REQ_PUSH_START, 5);
		add_req(REQ_PUSH_BYTE, 8'h00);
		add_req(REQ_PUSH_BYTE, 8'hFF);
		add_req(REQ_PUSH_BYTE, 8'hA5);
		add_req(REQ_PUSH_START, 65);
		add_req(REQ_PUSH_START, 127);
		add_req(REQ_POP, 63);
		add_req(REQ_POP, 16'hFFFF);
		add_req(REQ_POP, 64);
		add_req(REQ_POP, 0);
		add_req(REQ_CLEAR, 0);
		add_req(REQ_PUSH_BYTE, 8'h5A);
		wait_drain();

		// tiny ring: full ring, wrap and refusals; limit above the clamp
		run_phase(4, 127, 5, 1'b1);
		// zero limit: only zero-length packets, any reader capacity
		run_phase(37, 0, 4, 1'b0);
		run_phase(0, 2, 4, 1'b1);
		run_phase(2047, 64, 6, 1'b1);

		// one full-size packet on its own
		add_req(REQ_PUSH_START, 64);
		for (int k = 0; k < 64; k++) add_req(REQ_PUSH_BYTE, $urandom_range(0, 255));
		add_req(REQ_POP, 64);
		wait_drain();

		run_phase(100, 20, 6, 1'b0);
		repeat (16) @(posedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("[length_prefixed_packet_ring_core] OK");
		else
			$display("[length_prefixed_packet_ring_core] ERROR");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("[length_prefixed_packet_ring_core] ERROR");
		$finish;
	end

endmodule
